// ===== design/i2cms_pkg.sv =====
// Shared types and constants for the I2C master bit sequencer.
`default_nettype none

package i2cms_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam logic [15:0] PHASE_TICKS_RESET = 16'd720;

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 24;

    typedef enum logic [2:0] {
        CMD_START   = 3'd0,
        CMD_STOP    = 3'd1,
        CMD_TX_BYTE = 3'd2,
        CMD_RX_BYTE = 3'd3,
        CMD_TX_ACK  = 3'd4,
        CMD_RX_ACK  = 3'd5,
        CMD_TX_WORD = 3'd6,
        CMD_RX_WORD = 3'd7
    } cmd_t;

    // one tick as classified by the front end
    typedef struct packed {
        logic        is_cmd;
        cmd_t        cmd;
        logic [15:0] load;
        logic        sda;
    } item_t;

endpackage

`default_nettype wire

// ===== design/i2cms_front.sv =====
// Front end: unpacks incoming ticks and precomputes the shift register load value.
`default_nettype none

module i2cms_front
    import i2cms_pkg::*;
(
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // tx_data[15:0], ack_to_send, sda_in
    input  wire logic [S_TUSER_W-1:0] s_tuser,   // cmd_valid, func[2:0]
    output logic                      q_push,
    output item_t                     q_data,
    input  wire logic                 q_full
);

    cmd_t func;

    assign func     = cmd_t'(s_tuser[3:1]);
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_data.is_cmd = s_tuser[0];
        q_data.cmd    = func;
        q_data.sda    = s_tdata[17];
        unique case (func)
            CMD_TX_BYTE, CMD_TX_WORD: q_data.load = s_tdata[15:0];
            CMD_TX_ACK:               q_data.load = {15'd0, s_tdata[16]};
            default:                  q_data.load = 16'd0;
        endcase
    end

endmodule

`default_nettype wire

// ===== design/i2cms_queue.sv =====
// Small register FIFO between the front end and the sequencer.
`default_nettype none

module i2cms_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data,
    output logic                  empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== design/i2cms_back.sv =====
// Back end: pin action sequencer, phase timer and result register.
`default_nettype none

module i2cms_back
    import i2cms_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [15:0]          cfg_wr_data,
    input  wire logic                 q_empty,
    input  wire item_t                q_data,
    output logic                      q_pop,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata
);

    localparam int B3 = 3 * BITS_PER_BYTE;
    localparam logic [3:0] LO_TOP = 4'(BITS_PER_BYTE - 1);
    localparam logic [3:0] HI_TOP = 4'(2 * BITS_PER_BYTE - 1);
    localparam logic [5:0] B3_6 = 6'(B3);

    typedef enum logic [1:0] {
        ACT_SCL,
        ACT_SDA,
        ACT_RD,
        ACT_RACK
    } act_kind_t;

    typedef struct packed {
        act_kind_t  kind;
        logic       level;
        logic       from_shift;
        logic [3:0] pos;
    } act_t;

    // idx / 3 for idx < 64 via reciprocal multiply
    function automatic logic [5:0] div3(input logic [5:0] idx);
        logic [12:0] prod;
        prod = 13'(idx) * 13'd43;
        return prod[12:7];
    endfunction

    function automatic act_t tx_act(input logic [5:0] idx, input logic [3:0] top);
        logic [5:0] j;
        logic [5:0] r;
        act_t a;
        j = div3(idx);
        r = idx - 6'(3 * j);
        a.pos = top - j[3:0];
        if (r == 6'd0) begin
            a.kind = ACT_SDA;
            a.level = 1'b0;
            a.from_shift = 1'b1;
        end else begin
            a.kind = ACT_SCL;
            a.level = (r == 6'd1);
            a.from_shift = 1'b0;
        end
        return a;
    endfunction

    function automatic act_t rx_act(input logic [5:0] idx, input logic [3:0] top);
        logic [5:0] j;
        logic [5:0] r;
        act_t a;
        j = div3(idx);
        r = idx - 6'(3 * j);
        a.pos = top - j[3:0];
        a.from_shift = 1'b0;
        if (r == 6'd1) begin
            a.kind = ACT_RD;
            a.level = 1'b0;
        end else begin
            a.kind = ACT_SCL;
            a.level = (r == 6'd0);
        end
        return a;
    endfunction

    function automatic act_t fixed_act(input act_kind_t kind, input logic level);
        act_t a;
        a.kind = kind;
        a.level = level;
        a.from_shift = 1'b0;
        a.pos = 4'd0;
        return a;
    endfunction

    function automatic act_t rack_act(input logic [5:0] i);
        act_t a;
        priority if (i == 6'd0) a = fixed_act(ACT_SDA, 1'b1);
        else if (i == 6'd1)     a = fixed_act(ACT_SCL, 1'b1);
        else if (i == 6'd2)     a = fixed_act(ACT_RACK, 1'b0);
        else                    a = fixed_act(ACT_SCL, 1'b0);
        return a;
    endfunction

    function automatic act_t decode(input cmd_t cmd, input logic [5:0] idx);
        act_t a;
        unique case (cmd)
            CMD_START: begin
                priority if (idx == 6'd0) a = fixed_act(ACT_SDA, 1'b1);
                else if (idx == 6'd1)     a = fixed_act(ACT_SCL, 1'b1);
                else if (idx == 6'd2)     a = fixed_act(ACT_SDA, 1'b0);
                else                      a = fixed_act(ACT_SCL, 1'b0);
            end
            CMD_STOP: begin
                priority if (idx == 6'd0) a = fixed_act(ACT_SDA, 1'b0);
                else if (idx == 6'd1)     a = fixed_act(ACT_SCL, 1'b1);
                else                      a = fixed_act(ACT_SDA, 1'b1);
            end
            CMD_TX_BYTE: a = tx_act(idx, LO_TOP);
            CMD_RX_BYTE: begin
                if (idx == 6'd0) a = fixed_act(ACT_SDA, 1'b1);
                else             a = rx_act(idx - 6'd1, LO_TOP);
            end
            CMD_TX_ACK: begin
                if (idx == 6'd0) begin
                    a = fixed_act(ACT_SDA, 1'b0);
                    a.from_shift = 1'b1;
                end else begin
                    a = fixed_act(ACT_SCL, idx == 6'd1);
                end
            end
            CMD_RX_ACK: a = rack_act(idx);
            CMD_TX_WORD: begin
                priority if (idx < B3_6)    a = tx_act(idx, HI_TOP);
                else if (idx < B3_6 + 6'd4) a = rack_act(idx - B3_6);
                else                        a = tx_act(idx - B3_6 - 6'd4, LO_TOP);
            end
            CMD_RX_WORD: begin
                priority if (idx == 6'd0)        a = fixed_act(ACT_SDA, 1'b1);
                else if (idx < B3_6 + 6'd1)      a = rx_act(idx - 6'd1, HI_TOP);
                else if (idx == B3_6 + 6'd1)     a = fixed_act(ACT_SDA, 1'b0);
                else if (idx == B3_6 + 6'd2)     a = fixed_act(ACT_SCL, 1'b1);
                else if (idx == B3_6 + 6'd3)     a = fixed_act(ACT_SCL, 1'b0);
                else if (idx == B3_6 + 6'd4)     a = fixed_act(ACT_SDA, 1'b1);
                else                             a = rx_act(idx - B3_6 - 6'd5, LO_TOP);
            end
            default: a = fixed_act(ACT_SCL, 1'b0);
        endcase
        return a;
    endfunction

    function automatic logic [5:0] seq_len(input cmd_t cmd);
        logic [5:0] n;
        unique case (cmd)
            CMD_START:   n = 6'd4;
            CMD_STOP:    n = 6'd3;
            CMD_TX_BYTE: n = B3_6;
            CMD_RX_BYTE: n = B3_6 + 6'd1;
            CMD_TX_ACK:  n = 6'd3;
            CMD_RX_ACK:  n = 6'd4;
            CMD_TX_WORD: n = 6'(2 * B3 + 4);
            CMD_RX_WORD: n = 6'(2 * B3 + 5);
            default:     n = 6'd4;
        endcase
        return n;
    endfunction

    logic [15:0]          phase_reg;
    logic [15:0]          tick_reg, tick_next;
    logic [5:0]           step_reg, step_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [15:0]          shift_reg, shift_next;
    logic                 scl_reg, scl_next;
    logic                 sda_reg, sda_next;
    logic                 ack_reg, ack_next;
    logic                 busy_reg, busy_next;
    logic                 done_next;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [15:0] ph;
    logic [16:0] tick_inc;
    logic [5:0]  step_inc;
    act_t        act;
    logic [15:0] rx_out;

    assign q_pop    = !q_empty && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign ph       = (phase_reg == 16'd0) ? 16'd1 : phase_reg;

    always_comb begin
        cmd_next   = cmd_reg;
        shift_next = shift_reg;
        tick_next  = tick_reg;
        step_next  = step_reg;
        busy_next  = busy_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        ack_next   = ack_reg;
        done_next  = 1'b0;

        if (!busy_reg && q_data.is_cmd) begin
            cmd_next   = q_data.cmd;
            shift_next = q_data.load;
            busy_next  = 1'b1;
            step_next  = 6'd0;
            tick_next  = 16'd0;
        end

        act      = decode(cmd_next, step_next);
        tick_inc = {1'b0, tick_next} + 17'd1;
        step_inc = step_next + 6'd1;

        if (busy_next) begin
            if (tick_next == 16'd0) begin
                unique case (act.kind)
                    ACT_SCL: scl_next = act.level;
                    ACT_SDA: sda_next = act.from_shift ? shift_next[act.pos] : act.level;
                    ACT_RD: begin
                        if (q_data.sda) shift_next[act.pos] = 1'b1;
                    end
                    ACT_RACK: ack_next = q_data.sda;
                    default: ;
                endcase
            end
            if (tick_inc >= {1'b0, ph}) begin
                tick_next = 16'd0;
                step_next = step_inc;
                if (step_inc >= seq_len(cmd_next)) begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                    step_next = 6'd0;
                end
            end else begin
                tick_next = tick_inc[15:0];
            end
        end

        rx_out = (cmd_next == CMD_RX_BYTE || cmd_next == CMD_RX_WORD) ? shift_next : 16'd0;
        // scl, sda, busy, done, rx_data[15:0], ack_received
        m_tdata_next = {3'd0, ack_next, rx_out, done_next, busy_next, sda_next, scl_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PHASE_TICKS_RESET;
            tick_reg     <= 16'd0;
            step_reg     <= 6'd0;
            cmd_reg      <= CMD_START;
            shift_reg    <= 16'd0;
            scl_reg      <= 1'b1;
            sda_reg      <= 1'b1;
            ack_reg      <= 1'b1;
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                phase_reg <= cfg_wr_data;
            end
            if (q_pop) begin
                tick_reg  <= tick_next;
                step_reg  <= step_next;
                cmd_reg   <= cmd_next;
                shift_reg <= shift_next;
                scl_reg   <= scl_next;
                sda_reg   <= sda_next;
                ack_reg   <= ack_next;
                busy_reg  <= busy_next;
            end
            if (q_pop) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/i2c_master_bit_sequencer.sv =====
// I2C master bit sequencer: one input transaction per clock tick unless stalled, one result per tick.
//
// Usage: each slave-side transaction is one bus tick carrying the sampled SDA level
// and, when cmd_valid is set in tuser, a command (start, stop, byte/word send or
// receive, ack send or receive). While idle the block latches a command and plays
// its pin actions, each held for phase_ticks ticks. Every input transaction yields
// exactly one master-side result: SCL/SDA drive levels, busy, done, received data
// and received ack, reflecting the sequencer state after that tick.
// Throughput: one transaction per cycle in both directions while the receiver takes
// results. An accepted input transaction is registered in the queue, then the
// sequencer step loads its result into the output register.
// When the receiver stalls, the output register holds its result and the queue
// fills; s_tready drops only once the queue is full. Commands arriving while busy
// are ignored. Reset (aresetn low, synchronous) empties the queue, releases both
// lines, sets phase_ticks to 720 and returns to idle.
// cfg_wr_en writes phase_ticks at once; a value of zero acts as one.
`default_nettype none

module i2c_master_bit_sequencer
    import i2cms_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [15:0]          cfg_wr_data,  // phase_ticks
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,      // tx_data[15:0], ack_to_send, sda_in
    input  wire logic [S_TUSER_W-1:0] s_tuser,      // cmd_valid, func[2:0]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // scl_level, sda_level, busy_res, done_res, rx_data[15:0], ack_received
    output logic      [M_TDATA_W-1:0] m_tdata
);

    localparam int ITEM_W = $bits(item_t);

    logic  q_push;
    item_t q_in;
    logic  q_full;
    logic  q_pop;
    logic  q_empty;
    logic [ITEM_W-1:0] q_out_bits;

    i2cms_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_push   (q_push),
        .q_data   (q_in),
        .q_full   (q_full)
    );

    i2cms_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out_bits),
        .empty     (q_empty)
    );

    i2cms_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_empty     (q_empty),
        .q_data      (item_t'(q_out_bits)),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the I2C master bit sequencer stream interface.
`timescale 1ns / 100ps

module tb;
    import i2cms_pkg::*;

    localparam int BYTE_SLOTS  = 3 * BITS_PER_BYTE;
    localparam int RAND_TICKS  = 50;
    localparam int HOLD_CYCLES = 200;
    localparam int CYCLE_LIMIT = 1_500_000;

    typedef enum logic [1:0] {
        PIN_SCL,
        PIN_SDA,
        PIN_SAMPLE,
        PIN_ACK
    } pin_kind_t;

    typedef struct packed {
        pin_kind_t   kind;
        logic        lvl;
        logic [3:0]  pos;
    } pin_act_t;

    // one bus tick as offered on the slave side
    typedef struct packed {
        logic        cmd_valid;
        cmd_t        func;
        logic [15:0] tx;
        logic        ack_bit;
        logic        sda_bit;
    } tick_t;

    // master-side tdata layout, scl in bit 0
    typedef struct packed {
        logic [2:0]  pad;
        logic        ack;
        logic [15:0] rx;
        logic        done;
        logic        busy;
        logic        sda;
        logic        scl;
    } bus_res_t;

    typedef struct packed {
        tick_t       t;
        logic        poke;
        logic        typed;
        bus_res_t    want;
    } dir_row_t;

    localparam bus_res_t RESET_RES = '{pad: 3'd0, ack: 1'b1, rx: 16'd0, done: 1'b0,
                                       busy: 1'b0, sda: 1'b1, scl: 1'b1};

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [15:0]          cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic [S_TUSER_W-1:0] s_tuser     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // predicted sequencer state
    logic [15:0] m_phase = PHASE_TICKS_RESET;
    int unsigned m_ticks = 0;
    int          m_step  = 0;
    cmd_t        m_cmd   = CMD_START;
    logic [15:0] m_shift = '0;
    logic        m_scl   = 1'b1;
    logic        m_sda   = 1'b1;
    logic        m_ack   = 1'b1;
    logic        m_busy  = 1'b0;

    bus_res_t levels_due [$];
    dir_row_t dir_tab [$];
    int       mismatches  = 0;
    int       cycle_cnt   = 0;
    int       tx_idle_pct = 0;
    int       rx_idle_pct = 0;
    logic     hold_req    = 1'b0;
    logic     hold_taken  = 1'b0;
    int       stall_left  = 0;

    i2c_master_bit_sequencer dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic pin_act_t act(pin_kind_t k, logic l, logic [3:0] p);
        pin_act_t a;
        a.kind = k;
        a.lvl  = l;
        a.pos  = p;
        return a;
    endfunction

    function automatic pin_act_t tx_slot(int idx, int top);
        int j;
        int r;
        j = idx / 3;
        r = idx % 3;
        if (r == 0)
            return act(PIN_SDA, m_shift[4'(top - j)], 4'd0);
        return act(PIN_SCL, r == 1, 4'd0);
    endfunction

    function automatic pin_act_t rx_slot(int idx, int top);
        int j;
        int r;
        j = idx / 3;
        r = idx % 3;
        if (r == 1)
            return act(PIN_SAMPLE, 1'b0, 4'(top - j));
        return act(PIN_SCL, r == 0, 4'd0);
    endfunction

    function automatic pin_act_t ack_slot(int i);
        case (i)
            0:       return act(PIN_SDA, 1'b1, 4'd0);
            1:       return act(PIN_SCL, 1'b1, 4'd0);
            2:       return act(PIN_ACK, 1'b0, 4'd0);
            default: return act(PIN_SCL, 1'b0, 4'd0);
        endcase
    endfunction

    function automatic int seq_len(cmd_t c);
        case (c)
            CMD_START:   return 4;
            CMD_STOP:    return 3;
            CMD_TX_BYTE: return BYTE_SLOTS;
            CMD_RX_BYTE: return BYTE_SLOTS + 1;
            CMD_TX_ACK:  return 3;
            CMD_RX_ACK:  return 4;
            CMD_TX_WORD: return 2 * BYTE_SLOTS + 4;
            default:     return 2 * BYTE_SLOTS + 5;
        endcase
    endfunction

    function automatic pin_act_t pin_action(cmd_t c, int idx);
        case (c)
            CMD_START: begin
                if (idx == 0) return act(PIN_SDA, 1'b1, 4'd0);
                if (idx == 1) return act(PIN_SCL, 1'b1, 4'd0);
                if (idx == 2) return act(PIN_SDA, 1'b0, 4'd0);
                return act(PIN_SCL, 1'b0, 4'd0);
            end
            CMD_STOP: begin
                if (idx == 0) return act(PIN_SDA, 1'b0, 4'd0);
                if (idx == 1) return act(PIN_SCL, 1'b1, 4'd0);
                return act(PIN_SDA, 1'b1, 4'd0);
            end
            CMD_TX_BYTE: return tx_slot(idx, BITS_PER_BYTE - 1);
            CMD_RX_BYTE: begin
                if (idx == 0) return act(PIN_SDA, 1'b1, 4'd0);
                return rx_slot(idx - 1, BITS_PER_BYTE - 1);
            end
            CMD_TX_ACK: begin
                if (idx == 0) return act(PIN_SDA, m_shift[0], 4'd0);
                return act(PIN_SCL, idx == 1, 4'd0);
            end
            CMD_RX_ACK: return ack_slot(idx);
            CMD_TX_WORD: begin
                if (idx < BYTE_SLOTS) return tx_slot(idx, 2 * BITS_PER_BYTE - 1);
                if (idx < BYTE_SLOTS + 4) return ack_slot(idx - BYTE_SLOTS);
                return tx_slot(idx - BYTE_SLOTS - 4, BITS_PER_BYTE - 1);
            end
            default: begin
                // high byte, master ack low, release, low byte
                if (idx == 0) return act(PIN_SDA, 1'b1, 4'd0);
                if (idx < BYTE_SLOTS + 1) return rx_slot(idx - 1, 2 * BITS_PER_BYTE - 1);
                if (idx == BYTE_SLOTS + 1) return act(PIN_SDA, 1'b0, 4'd0);
                if (idx == BYTE_SLOTS + 2) return act(PIN_SCL, 1'b1, 4'd0);
                if (idx == BYTE_SLOTS + 3) return act(PIN_SCL, 1'b0, 4'd0);
                if (idx == BYTE_SLOTS + 4) return act(PIN_SDA, 1'b1, 4'd0);
                return rx_slot(idx - BYTE_SLOTS - 5, BITS_PER_BYTE - 1);
            end
        endcase
    endfunction

    // one bus tick of the sequencer; returns the levels after the tick
    function automatic bus_res_t advance_bus(tick_t t);
        bus_res_t    r;
        pin_act_t    a;
        int unsigned span;
        logic        done;
        done = 1'b0;
        if (!m_busy && t.cmd_valid) begin
            m_cmd = t.func;
            case (t.func)
                CMD_TX_BYTE, CMD_TX_WORD: m_shift = t.tx;
                CMD_TX_ACK:               m_shift = {15'd0, t.ack_bit};
                default:                  m_shift = '0;
            endcase
            m_busy  = 1'b1;
            m_step  = 0;
            m_ticks = 0;
        end
        if (m_busy) begin
            span = (m_phase == 16'd0) ? 1 : m_phase;
            if (m_ticks == 0) begin
                a = pin_action(m_cmd, m_step);
                case (a.kind)
                    PIN_SCL:    m_scl = a.lvl;
                    PIN_SDA:    m_sda = a.lvl;
                    PIN_SAMPLE: if (t.sda_bit) m_shift[a.pos] = 1'b1;
                    default:    m_ack = t.sda_bit;
                endcase
            end
            m_ticks++;
            if (m_ticks >= span) begin
                m_ticks = 0;
                m_step++;
                if (m_step >= seq_len(m_cmd)) begin
                    m_busy = 1'b0;
                    done   = 1'b1;
                    m_step = 0;
                end
            end
        end
        r      = '0;
        r.scl  = m_scl;
        r.sda  = m_sda;
        r.busy = m_busy;
        r.done = done;
        r.rx   = (m_cmd == CMD_RX_BYTE || m_cmd == CMD_RX_WORD) ? m_shift : 16'd0;
        r.ack  = m_ack;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_cnt);
        mismatches++;
    endtask

    task automatic check_result(bus_res_t got);
        bus_res_t want;
        if (levels_due.size() == 0) begin
            report_mismatch("result with nothing expected", got, 0);
            return;
        end
        want = levels_due.pop_front();
        if (got.scl !== want.scl)   report_mismatch("scl_level", got.scl, want.scl);
        if (got.sda !== want.sda)   report_mismatch("sda_level", got.sda, want.sda);
        if (got.busy !== want.busy) report_mismatch("busy", got.busy, want.busy);
        if (got.done !== want.done) report_mismatch("done", got.done, want.done);
        if (got.rx !== want.rx)     report_mismatch("rx_data", got.rx, want.rx);
        if (got.ack !== want.ack)   report_mismatch("ack_received", got.ack, want.ack);
    endtask

    // result side: check, then pick next tready (long hold-off once on request)
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_tvalid && m_tready)
                check_result(bus_res_t'(m_tdata));
            if (hold_req && !hold_taken) begin
                hold_taken <= 1'b1;
                stall_left <= HOLD_CYCLES;
                m_tready   <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_tready   <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_tick(tick_t t);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - 18){1'b0}}, t.sda_bit, t.ack_bit, t.tx};
        s_tuser  <= {t.func, t.cmd_valid};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        levels_due.push_back(advance_bus(t));
        if ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge aclk);
        end
    endtask

    function automatic tick_t random_tick();
        tick_t t;
        t.tx      = 16'($urandom);
        t.ack_bit = 1'($urandom);
        t.sda_bit = 1'($urandom);
        t.func    = cmd_t'($urandom_range(7));
        // mostly commands when idle, rare ignored ones while busy
        t.cmd_valid = m_busy ? ($urandom_range(99) < 5) : ($urandom_range(99) < 85);
        return t;
    endfunction

    // stop offering and wait for every accepted transaction's result
    task automatic drain();
        s_tvalid <= 1'b0;
        while (levels_due.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // finish the running command and wait for every result
    task automatic settle();
        tick_t t;
        while (m_busy) begin
            t = random_tick();
            t.cmd_valid = 1'b0;
            send_tick(t);
        end
        drain();
    endtask

    task automatic write_cfg(logic [15:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        m_phase = v;
    endtask

    task automatic write_phase(logic [15:0] v);
        settle();
        write_cfg(v);
    endtask

    initial begin
        tick_t t;
        tick_t f;

        dir_tab = '{
            '{'{1'b0, CMD_START,   16'h0000, 1'b0, 1'b1}, 1'b0, 1'b1, RESET_RES},
            '{'{1'b1, CMD_START,   16'h1234, 1'b1, 1'b1}, 1'b0, 1'b0, '0},
            '{'{1'b1, CMD_TX_BYTE, 16'h00FF, 1'b0, 1'b0}, 1'b0, 1'b0, '0},
            '{'{1'b1, CMD_TX_BYTE, 16'hFF00, 1'b1, 1'b1}, 1'b0, 1'b0, '0},
            '{'{1'b1, CMD_RX_ACK,  16'h0000, 1'b0, 1'b0}, 1'b0, 1'b0, '0},
            '{'{1'b1, CMD_RX_ACK,  16'hFFFF, 1'b0, 1'b1}, 1'b0, 1'b0, '0},
            '{'{1'b1, CMD_TX_ACK,  16'hFFFF, 1'b0, 1'b1}, 1'b0, 1'b0, '0},
            '{'{1'b1, CMD_TX_ACK,  16'h0000, 1'b1, 1'b0}, 1'b0, 1'b0, '0},
            '{'{1'b1, CMD_RX_BYTE, 16'h0000, 1'b0, 1'b1}, 1'b0, 1'b0, '0},
            '{'{1'b1, CMD_RX_BYTE, 16'hFFFF, 1'b1, 1'b0}, 1'b0, 1'b0, '0},
            '{'{1'b1, CMD_TX_WORD, 16'hFFFF, 1'b0, 1'b0}, 1'b0, 1'b0, '0},
            '{'{1'b1, CMD_TX_WORD, 16'h0000, 1'b1, 1'b1}, 1'b0, 1'b0, '0},
            '{'{1'b1, CMD_TX_WORD, 16'hA5C3, 1'b0, 1'b0}, 1'b0, 1'b0, '0},
            '{'{1'b1, CMD_RX_WORD, 16'h0000, 1'b0, 1'b1}, 1'b0, 1'b0, '0},
            '{'{1'b1, CMD_RX_WORD, 16'hFFFF, 1'b1, 1'b0}, 1'b0, 1'b0, '0},
            '{'{1'b1, CMD_START,   16'h5A5A, 1'b0, 1'b1}, 1'b1, 1'b0, '0},
            '{'{1'b1, CMD_STOP,    16'h0000, 1'b0, 1'b1}, 1'b0, 1'b0, '0},
            '{'{1'b0, CMD_RX_WORD, 16'hFFFF, 1'b1, 1'b0}, 1'b0, 1'b0, '0}
        };

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 34;
        rx_idle_pct = 66;
        foreach (dir_tab[i]) begin
            // zero phase (acts as one) once the reset-state tick is checked
            if (i == 1)
                write_phase(16'd0);
            send_tick(dir_tab[i].t);
            if (dir_tab[i].typed)
                levels_due[$] = dir_tab[i].want;
            if (dir_tab[i].poke) begin
                // command offered while busy must be dropped
                f      = dir_tab[i].t;
                f.func = CMD_RX_WORD;
                send_tick(f);
            end
            while (m_busy) begin
                f           = dir_tab[i].t;
                f.cmd_valid = 1'b0;
                send_tick(f);
            end
        end

        for (int mode = 0; mode < 3; mode++) begin
            tx_idle_pct = (mode == 0) ? 34 : (mode == 1) ? 66 : 0;
            rx_idle_pct = (mode == 0) ? 66 : (mode == 1) ? 34 : 0;
            for (int seg = 0; seg < 2; seg++) begin
                case (mode)
                    0:       write_phase(16'(seg + 1));
                    1:       write_phase(seg == 0 ? 16'd3 : 16'($urandom_range(6, 1)));
                    default: write_phase(seg == 0 ? 16'd1 : 16'($urandom_range(4, 1)));
                endcase
                if (mode == 2 && seg == 0)
                    hold_req <= 1'b1;
                repeat (RAND_TICKS) send_tick(random_tick());
            end
        end

        // widest phase on a stop, shortened by a write while the phase runs
        write_phase(16'hFFFF);
        t           = random_tick();
        t.cmd_valid = 1'b1;
        t.func      = CMD_STOP;
        send_tick(t);
        repeat (20) send_tick(random_tick());
        drain();
        write_cfg(16'd1);
        settle();

        // reset phase value on a start, shortened the same way
        write_phase(PHASE_TICKS_RESET);
        t.func = CMD_START;
        send_tick(t);
        repeat (20) send_tick(random_tick());
        drain();
        write_cfg(16'd2);
        settle();

        repeat (10) @(posedge aclk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
